// ===== rtl/core/sdtd_pkg.sv =====
// single/double tap detector: shared constants and widths
// no dependencies
`default_nettype none

package sdtd_pkg;

    localparam int FILTER_TAPS    = 5;
    localparam int WARMUP_SAMPLES = 10;
    localparam int SAMPLE_BITS    = 16;

    localparam int HIST_DEPTH = FILTER_TAPS - 1;
    localparam int SUM_W      = SAMPLE_BITS + $clog2(FILTER_TAPS);
    localparam int RISE_W     = SUM_W + 2;

    localparam int THR_W     = 12;
    localparam int LOCK_W    = 8;
    localparam int WIN_W     = 10;
    localparam int COUNT_W   = 8;
    localparam int WARM_W    = 4;
    localparam int LIMIT_W   = THR_W + $clog2(FILTER_TAPS);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 1 + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TAP_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SAMPLES  = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 12'd150;
    localparam logic [LOCK_W-1:0] LOCK_RESET = 8'd15;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 10'd200;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/core/single_double_tap_detector_unit.sv =====
// single/double tap detector top level: filter, tap counting, window classification
// depends on sdtd_pkg
`default_nettype none

// Takes one signed Z sample per word and, after ten warm-up samples, reports each
// closed tap window as one result word (double_tap, tap_count). A sample is taken
// in every cycle while the output is free or being drained; a result passes from
// the sample that closes the window through the input register, then through the
// combinational filter, rise compare and counter update into the output register.
// Throughput is one sample per cycle while the output is not stalled, bounded by
// the per-sample state update loop.
module single_double_tap_detector_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sdtd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sdtd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // sample stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sdtd_pkg::IN_TDATA_W-1:0]      s_tdata,   // z_sample
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sdtd_pkg::OUT_TDATA_W-1:0]          m_tdata    // double_tap, tap_count, zero pad
);
    import sdtd_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic [LOCK_W-1:0] lock_samples_reg;
    logic [WIN_W-1:0]  win_samples_reg;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic signed [SAMPLE_BITS-1:0] hist_reg [HIST_DEPTH];
    logic signed [SUM_W-1:0]       prev_sum_reg;
    logic [COUNT_W-1:0]            taps_reg, taps_next;
    logic [LOCK_W-1:0]             lock_cnt_reg, lock_cnt_next;
    logic                          lock_act_reg, lock_act_next;
    logic [WIN_W-1:0]              win_cnt_reg, win_cnt_next;
    logic [WARM_W-1:0]             warm_reg, warm_next;

    logic                out_valid_reg;
    logic                dbl_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                    advance;
    logic signed [SUM_W-1:0] sum_now;
    logic signed [RISE_W-1:0] rise_diff;
    logic [LIMIT_W-1:0]      limit;
    logic                    rise;
    logic                    emit;
    logic                    tested;
    logic                    warm_done;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, count_reg, dbl_reg};

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg          <= THR_RESET;
            lock_samples_reg <= LOCK_RESET;
            win_samples_reg  <= WIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TAP_THRESHOLD)
                thr_reg <= cfg_data[THR_W-1:0];
            else if (cfg_index == REG_LOCKOUT_SAMPLES)
                lock_samples_reg <= cfg_data[LOCK_W-1:0];
            else if (cfg_index == REG_WINDOW_SAMPLES)
                win_samples_reg <= cfg_data[WIN_W-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
    end

    // moving sum and rise test
    always_comb
    begin
        sum_now = SUM_W'(sample_reg);
        for (int i = 0; i < HIST_DEPTH; i++)
            sum_now = sum_now + SUM_W'(hist_reg[i]);
    end

    assign rise_diff = RISE_W'(sum_now) - RISE_W'(prev_sum_reg);
    assign limit     = LIMIT_W'(FILTER_TAPS) * LIMIT_W'(thr_reg);
    assign rise      = rise_diff >= $signed({{(RISE_W - LIMIT_W){1'b0}}, limit});
    assign warm_done = (warm_reg >= WARM_W'(WARMUP_SAMPLES));

    // tap counting, lockout and window
    always_comb
    begin
        taps_next     = taps_reg;
        lock_cnt_next = lock_cnt_reg;
        lock_act_next = lock_act_reg;
        win_cnt_next  = win_cnt_reg;
        warm_next     = warm_reg;
        emit          = 1'b0;
        tested        = 1'b0;
        if (!warm_done)
        begin
            warm_next = warm_reg + 1'b1;
        end
        else
        begin
            if (taps_next == '0)
            begin
                tested = 1'b1;
                if (rise)
                begin
                    taps_next     = taps_next + 1'b1;
                    lock_act_next = 1'b1;
                end
            end
            if (taps_next != '0 && lock_cnt_next < lock_samples_reg && lock_act_next)
            begin
                lock_cnt_next = lock_cnt_next + 1'b1;
            end
            else
            begin
                lock_cnt_next = '0;
                lock_act_next = 1'b0;
                if (!tested && rise)
                begin
                    if (taps_next != COUNT_MAX)
                        taps_next = taps_next + 1'b1;
                    lock_act_next = 1'b1;
                end
            end
            if (taps_next != '0)
                win_cnt_next = win_cnt_next + 1'b1;
            if (win_cnt_next >= win_samples_reg)
            begin
                win_cnt_next = '0;
                if (taps_next != '0)
                    emit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            prev_sum_reg <= '0;
            taps_reg     <= '0;
            lock_cnt_reg <= '0;
            lock_act_reg <= 1'b0;
            win_cnt_reg  <= '0;
            warm_reg     <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
                hist_reg[i] <= hist_reg[i+1];
            hist_reg[HIST_DEPTH-1] <= sample_reg;
            prev_sum_reg <= sum_now;
            taps_reg     <= emit ? '0 : taps_next;
            lock_cnt_reg <= lock_cnt_next;
            lock_act_reg <= lock_act_next;
            win_cnt_reg  <= win_cnt_next;
            warm_reg     <= warm_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            dbl_reg   <= (taps_next > COUNT_W'(1));
            count_reg <= taps_next;
        end
    end

    // checks
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg != '0))
        else $error("result with zero tap count");

    a_double_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (dbl_reg == (count_reg > COUNT_W'(1))))
        else $error("double_tap disagrees with tap_count");

    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (taps_reg == '0) |-> (win_cnt_reg == '0))
        else $error("window running with no taps pending");

    a_lockout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !lock_act_reg |-> (lock_cnt_reg == '0))
        else $error("lockout count set while lockout inactive");

    a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !warm_done |-> (taps_reg == '0 && !out_valid_reg))
        else $error("tap activity during warm-up");

endmodule

`default_nettype wire
